FILE: rtl/flx_pkg.sv
// Shared types and constants for the flux interval to nibble decoder.
// Used by flx_div and flux_interval_to_nibble_decoder_top; no dependencies.
package flx_pkg;

    localparam int TICK_NS   = 125;
    localparam int BT_W      = 16;
    localparam int LIMIT_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int HELD_W    = 3;
    localparam int MAX_OUT   = 5;
    localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

    localparam int INTV_MAX  = 2 * 255 * TICK_NS;
    localparam int INTV_W    = $clog2(INTV_MAX + 1);
    localparam int SUM_MAX   = ((1 << BT_W) - 2) + INTV_MAX + ((1 << BT_W) - 1);
    localparam int MAG_W     = $clog2(SUM_MAX + 1);
    localparam int SUM_W     = MAG_W + 1;
    localparam int DIV_W     = BT_W + 1;
    localparam int RES_W     = BT_W + 2;
    localparam int STEP_W    = $clog2(MAG_W + 1);

    localparam logic [INTV_W-1:0]    TICK2_V      = INTV_W'(2 * TICK_NS);
    localparam logic [BT_W-1:0]      DEFAULT_BT   = BT_W'(4000);
    localparam logic [LIMIT_W-1:0]   DEFAULT_LIM  = LIMIT_W'(65535);
    localparam logic [OUT_CNT_W-1:0] MAX_OUT_V    = OUT_CNT_W'(MAX_OUT);
    localparam logic [BYTE_W-1:0]    ESC_BYTE     = 8'hFF;
    localparam logic [BYTE_W-1:0]    SKIP_BYTE    = 8'h00;
    localparam logic [BYTE_W-1:0]    ESC_END_TICKS = 8'hFF;
    localparam logic [HELD_W-1:0]    HELD_FULL    = 3'd7;

    localparam logic CFG_BIT_TIME     = 1'b0;
    localparam logic CFG_NIBBLE_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FIX,
        ST_CELLS,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_res;

endpackage

FILE: rtl/flx_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on flx_pkg for widths and the result struct.
module flx_div import flx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output t_div_res         o_res
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [MAG_W-1:0]  r_quo, n_quo;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_dvs, n_dvs;
    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_diff;
    logic              w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[MAG_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(MAG_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            n_quo = {r_quo[MAG_W-2:0], w_ge};
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

FILE: rtl/flux_interval_to_nibble_decoder_top.sv
// A byte that yields no interval is consumed in ST_IDLE; otherwise it passes ST_LOAD, ST_DIV (waiting on
// the divider), ST_FIX, then ST_CELLS per cell shifted and ST_EMIT per nibble, plus any output stall.
// Throughput: one byte at a time; the next transfer is taken after the last nibble leaves.
// Reset: synchronous, active low; registers return to bit_time 4000, limit 65535.
// Top level of the flux interval decoder; depends on flx_pkg and flx_div.
module flux_interval_to_nibble_decoder_top import flx_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [BYTE_W-1:0]   i_flux_byte,
    input  logic                i_capture_end,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [BYTE_W-1:0]   o_nibble,
    output logic [LIMIT_W-1:0]  o_nibble_index,
    output logic                o_run_last,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [BT_W-1:0]     i_cfg_data
);

    t_state                r_state, n_state;
    logic [BT_W-1:0]       r_bit_time;
    logic [LIMIT_W-1:0]    r_limit;
    logic                  r_esc, n_esc;
    logic signed [RES_W-1:0] r_residual, n_residual;
    logic [BYTE_W-1:0]     r_shift, n_shift;
    logic [HELD_W-1:0]     r_held, n_held;
    logic [LIMIT_W-1:0]    r_ndone, n_ndone;
    logic [OUT_CNT_W-1:0]  r_count, n_count;
    logic                  r_last, n_last;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [MAG_W-1:0]      r_cells, n_cells;
    logic [BYTE_W-1:0]     r_nibble, n_nibble;
    logic [LIMIT_W-1:0]    r_index, n_index;
    logic                  r_run_last, n_run_last;

    logic [BT_W-1:0]       w_bt;
    logic [DIV_W-1:0]      w_dvs;
    logic                  w_accept;
    logic                  w_have;
    logic [BYTE_W-1:0]     w_ticks;
    logic [INTV_W-1:0]     w_intv;
    logic signed [SUM_W-1:0] w_neg_sum;
    logic [MAG_W-1:0]      w_mag;
    logic                  w_start;
    logic [DIV_W-1:0]      w_modv;
    logic                  w_stop;
    logic [BYTE_W-1:0]     w_byte;
    logic [LIMIT_W-1:0]    w_ndone_inc;
    t_div_res              w_div;

    assign w_bt      = (r_bit_time == '0) ? DEFAULT_BT : r_bit_time;
    assign w_dvs     = {w_bt, 1'b0};
    assign w_accept  = i_in_valid && o_in_ready;
    assign w_neg_sum = -r_sum;
    assign w_mag     = r_sum[SUM_W-1] ? w_neg_sum[MAG_W-1:0] : r_sum[MAG_W-1:0];
    assign w_intv    = INTV_W'(w_ticks) * TICK2_V;

    flx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_mag),
        .i_divisor  (w_dvs),
        .o_res      (w_div)
    );

    always_comb begin
        w_have = 1'b0;
        w_ticks = i_flux_byte;
        n_esc = r_esc;
        if (r_esc) begin
            n_esc  = 1'b0;
            w_have = 1'b1;
        end else if (i_flux_byte == ESC_BYTE) begin
            if (i_capture_end) begin
                w_ticks = ESC_END_TICKS;
                w_have  = 1'b1;
            end else begin
                n_esc = 1'b1;
            end
        end else if (i_flux_byte != SKIP_BYTE) begin
            w_have = 1'b1;
        end
        if (!w_accept) begin
            n_esc = r_esc;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_residual = r_residual;
        n_shift    = r_shift;
        n_held     = r_held;
        n_ndone    = r_ndone;
        n_count    = r_count;
        n_last     = r_last;
        n_sum      = r_sum;
        n_cells    = r_cells;
        n_nibble   = r_nibble;
        n_index    = r_index;
        n_run_last = r_run_last;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        w_start    = 1'b0;
        w_modv     = '0;
        w_byte     = {r_shift[BYTE_W-2:0], (r_cells == MAG_W'(1))};
        w_ndone_inc = r_ndone + LIMIT_W'(1);
        w_stop     = (r_cells == '0) || (r_ndone >= r_limit) || (r_count == MAX_OUT_V);
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    n_last  = i_capture_end;
                    n_count = '0;
                    n_sum   = {{(SUM_W-RES_W){r_residual[RES_W-1]}}, r_residual}
                            + $signed({{(SUM_W-INTV_W){1'b0}}, w_intv})
                            + $signed({{(SUM_W-BT_W){1'b0}}, w_bt});
                    if (w_have) begin
                        n_state = ST_LOAD;
                    end else if (i_capture_end) begin
                        n_residual = '0;
                        n_shift    = '0;
                        n_held     = '0;
                        n_ndone    = '0;
                    end
                end
            end
            ST_LOAD: begin
                w_start = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                if (!r_sum[SUM_W-1]) begin
                    w_modv  = w_div.rem;
                    n_cells = w_div.quo;
                end else begin
                    w_modv  = (w_div.rem == '0) ? '0 : (w_dvs - w_div.rem);
                    n_cells = '0;
                end
                n_residual = $signed({1'b0, w_modv}) - $signed({2'b00, w_bt});
                n_state    = ST_CELLS;
            end
            ST_CELLS: begin
                if (w_stop) begin
                    if (r_last) begin
                        n_residual = '0;
                        n_shift    = '0;
                        n_held     = '0;
                        n_ndone    = '0;
                    end
                    n_state = ST_IDLE;
                end else begin
                    n_cells = r_cells - MAG_W'(1);
                    if (r_held == HELD_FULL) begin
                        n_nibble   = w_byte;
                        n_index    = r_ndone;
                        n_run_last = !((r_cells > MAG_W'(BYTE_W))
                                    && (r_count < MAX_OUT_V - OUT_CNT_W'(1))
                                    && (w_ndone_inc < r_limit));
                        n_shift    = '0;
                        n_held     = '0;
                        n_ndone    = w_ndone_inc;
                        n_count    = r_count + OUT_CNT_W'(1);
                        n_state    = ST_EMIT;
                    end else begin
                        n_shift = w_byte;
                        n_held  = r_held + HELD_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_CELLS;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_bit_time <= DEFAULT_BT;
            r_limit    <= DEFAULT_LIM;
            r_esc      <= 1'b0;
            r_residual <= '0;
            r_shift    <= '0;
            r_held     <= '0;
            r_ndone    <= '0;
            r_count    <= '0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_esc      <= (n_state == ST_IDLE && r_state != ST_IDLE && r_last) ? 1'b0 : n_esc;
            r_residual <= n_residual;
            r_shift    <= n_shift;
            r_held     <= n_held;
            r_ndone    <= n_ndone;
            r_count    <= n_count;
            r_last     <= n_last;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIT_TIME:     r_bit_time <= i_cfg_data;
                    CFG_NIBBLE_LIMIT: r_limit    <= i_cfg_data;
                    default:          r_limit    <= r_limit;
                endcase
            end
        end
        r_sum      <= n_sum;
        r_cells    <= n_cells;
        r_nibble   <= n_nibble;
        r_index    <= n_index;
        r_run_last <= n_run_last;
    end

    assign o_nibble       = r_nibble;
    assign o_nibble_index = r_index;
    assign o_run_last     = r_run_last;

    a_ready_xor_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a nibble is offered");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_OUT_V)
        else $error("more nibbles than allowed for one byte");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_run_last) |=> !o_in_ready)
        else $error("item ended after a nibble not marked last");

    a_group_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_held == '0 && r_shift == '0))
        else $error("bit group not cleared after forming a nibble");

endmodule
